// ----- rtl/core/octnav_pkg.sv -----
// ----------------------------------------------------------------------------
// octnav_pkg
// Shared types and constants for the octant navigation and Morton compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package octnav_pkg;

    localparam int LEVEL_W       = 5;
    localparam int COORD_W       = 32;
    localparam int PICK_W        = 4;
    localparam int CMD_W         = 3;
    localparam int CIDX_W        = 3;
    localparam int ORDER_W       = 2;
    localparam int NUM_AXES      = 3;
    localparam int MAX_LEVEL_DEF = 30;

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CHILD_INDEX     = 3'd0,
        CMD_SIBLING         = 3'd1,
        CMD_PARENT          = 3'd2,
        CMD_FACE            = 3'd3,
        CMD_EDGE            = 3'd4,
        CMD_CORNER          = 3'd5,
        CMD_COMPARE         = 3'd6,
        CMD_COMPARE_NOLEVEL = 3'd7
    } cmd_t;

    // compare result codes
    localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'b11;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'b01;

    // one octant: level and anchor
    typedef struct packed {
        logic [LEVEL_W-1:0]        level;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } octant_t;

endpackage

`default_nettype wire

// ----- rtl/core/octant_navigate_and_morton_compare.sv -----
// done marks a result after the input register and the result register.
// Throughput: one item per cycle; busy is always low, the input register
// and the result register form a two-stage pipeline.
// Reset clears only the valid flags of both stages; no item is in flight.
// The receiver cannot stall: done marks each result for one cycle.
// ----------------------------------------------------------------------------
// octant_navigate_and_morton_compare
// Octant navigation (child index, sibling, parent, face/edge/corner neighbor)
// and Morton order compare, registered single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module octant_navigate_and_morton_compare
    import octnav_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [CMD_W-1:0]          cmd,
    input  wire logic [LEVEL_W-1:0]        own_level,
    input  wire logic signed [COORD_W-1:0] own_x,
    input  wire logic signed [COORD_W-1:0] own_y,
    input  wire logic signed [COORD_W-1:0] own_z,
    input  wire logic [PICK_W-1:0]         pick,
    input  wire logic [LEVEL_W-1:0]        other_level,
    input  wire logic signed [COORD_W-1:0] other_x,
    input  wire logic signed [COORD_W-1:0] other_y,
    input  wire logic signed [COORD_W-1:0] other_z,
    output logic                           done,
    output logic [LEVEL_W-1:0]             res_level,
    output logic signed [COORD_W-1:0]      res_x,
    output logic signed [COORD_W-1:0]      res_y,
    output logic signed [COORD_W-1:0]      res_z,
    output logic [CIDX_W-1:0]              child_index,
    output logic signed [ORDER_W-1:0]      order
);

    localparam logic [LEVEL_W-1:0] MAX_LV = LEVEL_W'(MAX_LEVEL);

    logic                valid_reg;
    cmd_t                cmd_reg;
    octant_t             own_reg;
    octant_t             other_reg;
    logic [PICK_W-1:0]   pick_reg;

    logic                done_reg;
    logic [LEVEL_W-1:0]  res_level_reg;
    logic [COORD_W-1:0]  res_coord_reg [NUM_AXES];
    logic [CIDX_W-1:0]   child_index_reg;
    logic [ORDER_W-1:0]  order_reg;

    logic [LEVEL_W-1:0]  res_level_next;
    logic [COORD_W-1:0]  res_coord_next [NUM_AXES];
    logic [CIDX_W-1:0]   child_index_next;
    logic [ORDER_W-1:0]  order_next;

    logic [LEVEL_W-1:0]  lv_sat;
    logic [LEVEL_W-1:0]  h_shift;
    logic [COORD_W-1:0]  h;
    logic [COORD_W-1:0]  c     [NUM_AXES];
    logic [COORD_W-1:0]  c_add [NUM_AXES];
    logic [COORD_W-1:0]  c_sub [NUM_AXES];
    logic [COORD_W-1:0]  c_base[NUM_AXES];
    logic                pick_odd;
    logic [ORDER_W-1:0]  cmp_order;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg   <= cmd_t'(cmd);
            own_reg   <= '{level: own_level, x: own_x, y: own_y, z: own_z};
            other_reg <= '{level: other_level, x: other_x, y: other_y, z: other_z};
            pick_reg  <= pick;
        end
    end

    // side length from the level saturated at the deepest level
    assign lv_sat  = (own_reg.level > MAX_LV) ? MAX_LV : own_reg.level;
    assign h_shift = MAX_LV - lv_sat;
    assign h       = COORD_W'(1) << h_shift;

    assign c[0] = own_reg.x;
    assign c[1] = own_reg.y;
    assign c[2] = own_reg.z;

    // per-axis step candidates
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            c_add[i]  = c[i] + h;
            c_sub[i]  = c[i] - h;
            c_base[i] = c[i] & ~h;
        end
    end

    assign pick_odd = pick_reg[0];

    octnav_cmp u_cmp (
        .a         (own_reg),
        .b         (other_reg),
        .use_level (cmd_reg == CMD_COMPARE),
        .order     (cmp_order)
    );

    // operation select
    always_comb
    begin
        res_level_next   = '0;
        child_index_next = '0;
        order_next       = ORDER_EQUAL;
        for (int i = 0; i < NUM_AXES; i++)
            res_coord_next[i] = '0;

        unique case (cmd_reg)
            CMD_CHILD_INDEX:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                    child_index_next[i] = |(c[i] & h);
            end
            CMD_SIBLING:
            begin
                res_level_next = own_reg.level;
                for (int i = 0; i < NUM_AXES; i++)
                    res_coord_next[i] = pick_reg[i] ? (c_base[i] + h) : c_base[i];
            end
            CMD_PARENT:
            begin
                if (own_reg.level != '0)
                begin
                    res_level_next = own_reg.level - LEVEL_W'(1);
                    for (int i = 0; i < NUM_AXES; i++)
                        res_coord_next[i] = c_base[i];
                end
                else
                begin
                    res_level_next = own_reg.level;
                    for (int i = 0; i < NUM_AXES; i++)
                        res_coord_next[i] = c[i];
                end
            end
            CMD_FACE:
            begin
                res_level_next = own_reg.level;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    if (pick_reg == PICK_W'(2 * i))
                        res_coord_next[i] = c_sub[i];
                    else if (pick_reg == PICK_W'(2 * i + 1))
                        res_coord_next[i] = c_add[i];
                    else
                        res_coord_next[i] = c[i];
                end
            end
            CMD_EDGE:
            begin
                res_level_next = own_reg.level;
                priority if (pick_reg < PICK_W'(4))
                begin
                    res_coord_next[0] = c[0];
                    res_coord_next[1] = pick_odd ? c_add[1] : c_sub[1];
                    res_coord_next[2] = (pick_reg < PICK_W'(2)) ? c_sub[2] : c_add[2];
                end
                else if (pick_reg < PICK_W'(8))
                begin
                    res_coord_next[1] = c[1];
                    res_coord_next[0] = pick_odd ? c_add[0] : c_sub[0];
                    res_coord_next[2] = (pick_reg < PICK_W'(6)) ? c_sub[2] : c_add[2];
                end
                else
                begin
                    res_coord_next[2] = c[2];
                    res_coord_next[0] = pick_odd ? c_add[0] : c_sub[0];
                    res_coord_next[1] = (pick_reg < PICK_W'(10)) ? c_sub[1] : c_add[1];
                end
            end
            CMD_CORNER:
            begin
                res_level_next = own_reg.level;
                for (int i = 0; i < NUM_AXES; i++)
                    res_coord_next[i] = pick_reg[i] ? c_add[i] : c_sub[i];
            end
            CMD_COMPARE,
            CMD_COMPARE_NOLEVEL:
            begin
                order_next = cmp_order;
            end
            default:
            begin
                order_next = ORDER_EQUAL;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            res_level_reg   <= res_level_next;
            child_index_reg <= child_index_next;
            order_reg       <= order_next;
            for (int i = 0; i < NUM_AXES; i++)
                res_coord_reg[i] <= res_coord_next[i];
        end
    end

    assign done        = done_reg;
    assign res_level   = res_level_reg;
    assign res_x       = res_coord_reg[0];
    assign res_y       = res_coord_reg[1];
    assign res_z       = res_coord_reg[2];
    assign child_index = child_index_reg;
    assign order       = order_reg;

    // every transfer yields a result via the input and result registers
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("start transfer without result");

    // no result without a matching earlier start transfer
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without start transfer");

    // compare result never takes the unused code
    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> order != 2'b10)
        else $error("order out of range");

    // nonzero order only from a compare, with res_level and child_index clear
    a_order_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && order != ORDER_EQUAL) |-> (res_level == '0 && child_index == '0))
        else $error("compare result mixed with navigation fields");

endmodule

`default_nettype wire

// ----- rtl/core/octnav_cmp.sv -----
// ----------------------------------------------------------------------------
// octnav_cmp
// Morton (z-order) compare of two octants, result as less / equal / greater.
// ----------------------------------------------------------------------------
`default_nettype none

module octnav_cmp
    import octnav_pkg::*;
(
    input  wire octant_t            a,
    input  wire octant_t            b,
    input  wire logic               use_level,
    output logic [ORDER_W-1:0]      order
);

    logic [COORD_W-1:0] xd;
    logic [COORD_W-1:0] yd;
    logic [COORD_W-1:0] zd;
    logic [COORD_W-1:0] all_d;
    logic               x_wins;
    logic               y_wins;
    logic signed [COORD_W-1:0] pa;
    logic signed [COORD_W-1:0] pb;

    // per-axis differing bits
    assign xd    = a.x ^ b.x;
    assign yd    = a.y ^ b.y;
    assign zd    = a.z ^ b.z;
    assign all_d = xd | yd | zd;

    // axis holding the most significant differing bit, x before y before z
    assign x_wins = xd > (all_d ^ xd);
    assign y_wins = yd > (all_d ^ yd);

    // deciding coordinate pair
    always_comb
    begin
        priority if (x_wins)
        begin
            pa = a.x;
            pb = b.x;
        end
        else if (y_wins)
        begin
            pa = a.y;
            pb = b.y;
        end
        else
        begin
            pa = a.z;
            pb = b.z;
        end
    end

    // signed compare of deciding axis, level tie-break on equal anchors if use_level
    always_comb
    begin
        priority if (all_d == '0)
        begin
            if (!use_level || a.level == b.level)
                order = ORDER_EQUAL;
            else if (a.level > b.level)
                order = ORDER_GREATER;
            else
                order = ORDER_LESS;
        end
        else if (pa > pb)
            order = ORDER_GREATER;
        else if (pa < pb)
            order = ORDER_LESS;
        else
            order = ORDER_EQUAL;
    end

endmodule

`default_nettype wire
